/* rtl/assert_macros.svh */
// Assertion macros for the escape-time pixel core.
// Full property checks in simulation; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define MBE_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: invariant");

`define MBE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

`define MBE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define MBE_ASSERT_ALWAYS(label, clk, rst, cond)
`define MBE_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define MBE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/mbe_pkg.sv */
// Shared types, constants and helpers for the escape-time pixel core.
// No dependencies; used by mbe_csr_regs and the top level.
`default_nettype none

package mbe_pkg;

   localparam int unsigned IMAGE_SIZE    = 1024;
   localparam int unsigned FRACTION_BITS = 28;

   localparam int unsigned COORD_W = 10;
   localparam int unsigned INDEX_W = 20;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned COLOR_W = 32;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned STEP_W  = 31;
   localparam int unsigned PROD_W  = 2 * VALUE_W;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   // |z|^2 carries 2*FRACTION_BITS fraction bits; 4.0 sits two bits above that
   localparam int unsigned ESCAPE_SHIFT = 2 * FRACTION_BITS + 2;
   localparam bit          ESCAPE_ON    = (ESCAPE_SHIFT < PROD_W);
   localparam logic [PROD_W:0] ESCAPE_BOUND =
      ESCAPE_ON ? ((PROD_W + 1)'(1) << ESCAPE_SHIFT) : '0;

   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_STEP      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_REAL     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_IMAG     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_COLOR      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ITERATION_LIMIT = 3'd4;

   localparam logic [STEP_W-1:0]  RESET_PIXEL_STEP      = 31'd787201;
   localparam logic [VALUE_W-1:0] RESET_OFFSET_REAL     = 32'hDF333333;
   localparam logic [VALUE_W-1:0] RESET_OFFSET_IMAG     = 32'hEB333333;
   localparam logic [COLOR_W-1:0] RESET_BASE_COLOR      = 32'd13172733;
   localparam logic [COUNT_W-1:0] RESET_ITERATION_LIMIT = 16'd100;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] pixel_index;
      logic [COUNT_W-1:0] iteration_count;
      logic [COLOR_W-1:0] pixel_color;
   } rsp_type;

   typedef struct packed {
      logic [STEP_W-1:0]  pixel_step;
      logic [VALUE_W-1:0] offset_real;
      logic [VALUE_W-1:0] offset_imag;
      logic [COLOR_W-1:0] base_color;
      logic [COUNT_W-1:0] iteration_limit;
   } cfg_type;

   function automatic logic signed [VALUE_W-1:0] sat_value(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = {{(PROD_W - VALUE_W + 1){1'b0}}, {(VALUE_W - 1){1'b1}}};
      lo = ~hi;
      if (v > hi) begin
         return hi[VALUE_W-1:0];
      end else if (v < lo) begin
         return lo[VALUE_W-1:0];
      end
      return v[VALUE_W-1:0];
   endfunction

   function automatic logic signed [PROD_W-1:0] sext_value(input logic [VALUE_W-1:0] v);
      return $signed({{(PROD_W - VALUE_W){v[VALUE_W-1]}}, v});
   endfunction

endpackage

`default_nettype wire

/* rtl/mbe_csr_regs.sv */
// Configuration register file for the escape-time pixel core.
// Depends on mbe_pkg for register indexes, reset values and cfg_type.
`default_nettype none

module mbe_csr_regs (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [mbe_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [mbe_pkg::CSR_DATA_W-1:0]      csr_data,
   output mbe_pkg::cfg_type                         cfg
);

   mbe_pkg::cfg_type cfg_ff;
   mbe_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            mbe_pkg::CSR_PIXEL_STEP: begin
               cfg_in.pixel_step = csr_data[mbe_pkg::STEP_W-1:0];
            end
            mbe_pkg::CSR_OFFSET_REAL: begin
               cfg_in.offset_real = csr_data[mbe_pkg::VALUE_W-1:0];
            end
            mbe_pkg::CSR_OFFSET_IMAG: begin
               cfg_in.offset_imag = csr_data[mbe_pkg::VALUE_W-1:0];
            end
            mbe_pkg::CSR_BASE_COLOR: begin
               cfg_in.base_color = csr_data[mbe_pkg::COLOR_W-1:0];
            end
            mbe_pkg::CSR_ITERATION_LIMIT: begin
               cfg_in.iteration_limit = csr_data[mbe_pkg::COUNT_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_step      <= mbe_pkg::RESET_PIXEL_STEP;
         cfg_ff.offset_real     <= mbe_pkg::RESET_OFFSET_REAL;
         cfg_ff.offset_imag     <= mbe_pkg::RESET_OFFSET_IMAG;
         cfg_ff.base_color      <= mbe_pkg::RESET_BASE_COLOR;
         cfg_ff.iteration_limit <= mbe_pkg::RESET_ITERATION_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/mandelbrot_escape_time_pixel_core.sv */
// Escape-time pixel core: maps a pixel to c, iterates z = z*z + c, returns count and color.
// Depends on mbe_pkg, mbe_csr_regs and assert_macros.svh.
//
//   channel | direction | handshake            | word
//   req     | in        | req_valid, req_stall | mbe_pkg::req_type
//   rsp     | out       | rsp_valid, rsp_stall | mbe_pkg::rsp_type
//   csr     | in        | csr_valid, csr_ready | csr_index, csr_data
//
// One signed 32x32 multiplier with a registered product forms zr^2, zi^2 and zr*zi in turn
// each iteration. Mapping the pixel to c and the color product use the same multiplier.
// Reset loads the register defaults and empties the result register; no clearing pass.
// A finished word waits in the result register, so the next pixel is accepted meanwhile;
// the core holds in its last step while that word is still stalled.
`default_nettype none

`include "assert_macros.svh"

module mandelbrot_escape_time_pixel_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire mbe_pkg::req_type                req_word,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output mbe_pkg::rsp_type                     rsp_word,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [mbe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [mbe_pkg::CSR_DATA_W-1:0]  csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CR,
      ST_CI,
      ST_SQI,
      ST_CROSS,
      ST_UPDATE,
      ST_FINISH,
      ST_COLOR
   } state_type;

   mbe_pkg::cfg_type cfg;

   state_type                               state_ff, state_in;
   logic [mbe_pkg::COORD_W-1:0]             py_ff, py_in;
   logic [mbe_pkg::INDEX_W-1:0]             index_ff, index_in;
   logic [mbe_pkg::COUNT_W-1:0]             limit_ff, limit_in;
   logic [mbe_pkg::COUNT_W-1:0]             count_ff, count_in;
   logic signed [mbe_pkg::VALUE_W-1:0]      cr_ff, cr_in;
   logic signed [mbe_pkg::VALUE_W-1:0]      ci_ff, ci_in;
   logic signed [mbe_pkg::VALUE_W-1:0]      zr_ff, zr_in;
   logic signed [mbe_pkg::VALUE_W-1:0]      zi_ff, zi_in;
   logic signed [mbe_pkg::VALUE_W-1:0]      nr_ff, nr_in;
   logic signed [mbe_pkg::PROD_W-1:0]       rr_ff, rr_in;
   logic signed [mbe_pkg::PROD_W-1:0]       prod_ff, prod_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   mbe_pkg::rsp_type                        rsp_word_ff, rsp_word_in;

   logic signed [mbe_pkg::VALUE_W-1:0]      mul_a;
   logic signed [mbe_pkg::VALUE_W-1:0]      mul_b;
   logic signed [mbe_pkg::VALUE_W-1:0]      step_s;
   logic [mbe_pkg::PROD_W:0]                mag;
   logic                                    escape;
   logic signed [mbe_pkg::PROD_W-1:0]       real_sum;
   logic signed [mbe_pkg::PROD_W-1:0]       imag_sum;
   logic [mbe_pkg::COUNT_W:0]               count_next;
   logic [mbe_pkg::INDEX_W+mbe_pkg::COORD_W+2:0] index_full;
   logic                                    out_free;

   mbe_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign step_s = $signed({1'b0, cfg.pixel_step});

   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            mul_a = $signed(mbe_pkg::VALUE_W'(req_word.pixel_x));
            mul_b = step_s;
         end
         ST_CR: begin
            mul_a = $signed(mbe_pkg::VALUE_W'(py_ff));
            mul_b = step_s;
         end
         ST_CI: begin
            mul_a = zr_ff;
            mul_b = zr_ff;
         end
         ST_SQI: begin
            mul_a = zi_ff;
            mul_b = zi_ff;
         end
         ST_CROSS: begin
            mul_a = zr_ff;
            mul_b = zi_ff;
         end
         ST_UPDATE: begin
            mul_a = nr_ff;
            mul_b = nr_ff;
         end
         ST_FINISH, ST_COLOR: begin
            mul_a = $signed(cfg.base_color);
            mul_b = $signed(mbe_pkg::VALUE_W'(count_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mag    = {1'b0, rr_ff} + {1'b0, prod_ff};
   assign escape = mbe_pkg::ESCAPE_ON && (mag >= mbe_pkg::ESCAPE_BOUND);

   assign real_sum = ((rr_ff - prod_ff) >>> mbe_pkg::FRACTION_BITS)
                     + mbe_pkg::sext_value(cr_ff);
   assign imag_sum = (prod_ff >>> (mbe_pkg::FRACTION_BITS - 1))
                     + mbe_pkg::sext_value(ci_ff);

   assign count_next = {1'b0, count_ff} + 1'b1;
   assign index_full = ($bits(index_full))'(req_word.pixel_y)
                       * ($bits(index_full))'(mbe_pkg::IMAGE_SIZE)
                       + ($bits(index_full))'(req_word.pixel_x);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      py_in        = py_ff;
      index_in     = index_ff;
      limit_in     = limit_ff;
      count_in     = count_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      nr_in        = nr_ff;
      rr_in        = rr_ff;
      prod_in      = mul_a * mul_b;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               py_in    = req_word.pixel_y;
               index_in = index_full[mbe_pkg::INDEX_W-1:0];
               limit_in = cfg.iteration_limit;
               count_in = '0;
               zr_in    = '0;
               zi_in    = '0;
               state_in = ST_CR;
            end
         end
         ST_CR: begin
            cr_in    = mbe_pkg::sat_value(prod_ff + mbe_pkg::sext_value(cfg.offset_real));
            state_in = ST_CI;
         end
         ST_CI: begin
            ci_in    = mbe_pkg::sat_value(prod_ff + mbe_pkg::sext_value(cfg.offset_imag));
            state_in = (limit_ff == '0) ? ST_FINISH : ST_SQI;
         end
         ST_SQI: begin
            rr_in    = prod_ff;
            state_in = ST_CROSS;
         end
         ST_CROSS: begin
            if (escape) begin
               state_in = ST_FINISH;
            end else begin
               nr_in    = mbe_pkg::sat_value(real_sum);
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            zi_in    = mbe_pkg::sat_value(imag_sum);
            zr_in    = nr_ff;
            count_in = count_next[mbe_pkg::COUNT_W-1:0];
            state_in = (count_next == {1'b0, limit_ff}) ? ST_FINISH : ST_SQI;
         end
         ST_FINISH: begin
            state_in = ST_COLOR;
         end
         ST_COLOR: begin
            if (out_free) begin
               rsp_word_in.pixel_index     = index_ff;
               rsp_word_in.iteration_count = count_ff;
               rsp_word_in.pixel_color     = (count_ff == limit_ff) ? '0
                                             : prod_ff[mbe_pkg::COLOR_W-1:0];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      py_ff       <= py_in;
      index_ff    <= index_in;
      cr_ff       <= cr_in;
      ci_ff       <= ci_in;
      zr_ff       <= zr_in;
      zi_ff       <= zi_in;
      nr_ff       <= nr_in;
      rr_ff       <= rr_in;
      prod_ff     <= prod_in;
      rsp_word_ff <= rsp_word_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         limit_ff     <= limit_in;
         count_ff     <= count_in;
      end
   end

   `MBE_ASSERT_ALWAYS(a_count_within_limit, clock, reset, count_ff <= limit_ff)
   `MBE_ASSERT_IMPLIES(a_escape_before_limit, clock, reset, (state_ff == ST_CROSS) && escape, count_ff < limit_ff)
   `MBE_ASSERT_IMPLIES(a_inside_is_black, clock, reset, rsp_valid_ff && (rsp_word_ff.iteration_count == limit_ff), rsp_word_ff.pixel_color == '0)
   `MBE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

endmodule

`default_nettype wire

/* dv/mbe_tb_pkg.sv */
// Result predictor and in-order checker for the escape-time pixel core bench.
// Mirrors the five core registers and iterates z = z*z + c in Q4.28 per pixel.
// Depends on mbe_pkg for the word types, widths and register indexes.
package mbe_tb_pkg;
   import mbe_pkg::*;

   class pixel_scoreboard;
      logic [STEP_W-1:0]  step;
      logic [VALUE_W-1:0] origin_re;
      logic [VALUE_W-1:0] origin_im;
      logic [COLOR_W-1:0] tint;
      logic [COUNT_W-1:0] max_iter;
      rsp_type            pending[$];
      int unsigned        faults;

      function new();
         step      = RESET_PIXEL_STEP;
         origin_re = RESET_OFFSET_REAL;
         origin_im = RESET_OFFSET_IMAG;
         tint      = RESET_BASE_COLOR;
         max_iter  = RESET_ITERATION_LIMIT;
         faults    = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_PIXEL_STEP:      step      = data[STEP_W-1:0];
            CSR_OFFSET_REAL:     origin_re = data[VALUE_W-1:0];
            CSR_OFFSET_IMAG:     origin_im = data[VALUE_W-1:0];
            CSR_BASE_COLOR:      tint      = data[COLOR_W-1:0];
            CSR_ITERATION_LIMIT: max_iter  = data[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      function longint clamp_q(longint v);
         if (v > 64'sh7FFF_FFFF) begin
            return 64'sh7FFF_FFFF;
         end
         if (v < -64'sh8000_0000) begin
            return -64'sh8000_0000;
         end
         return v;
      endfunction

      // escape-time iteration for one accepted pixel
      function void note_pixel(req_type px);
         longint             cr, ci, zr, zi, rr, ii;
         logic [63:0]        mag;
         logic [63:0]        bound;
         int unsigned        count;
         logic [COLOR_W-1:0] shade;
         rsp_type            r;
         bound = 64'd1 << (2 * FRACTION_BITS + 2);
         cr = clamp_q(longint'(px.pixel_x) * longint'(step) + longint'($signed(origin_re)));
         ci = clamp_q(longint'(px.pixel_y) * longint'(step) + longint'($signed(origin_im)));
         zr = 0;
         zi = 0;
         count = 0;
         while (count < max_iter) begin
            rr = zr * zr;
            ii = zi * zi;
            mag = rr + ii;
            if (mag >= bound) begin
               break;
            end
            rr = ((rr - ii) >>> FRACTION_BITS) + cr;
            ii = ((zr * zi) >>> (FRACTION_BITS - 1)) + ci;
            zr = clamp_q(rr);
            zi = clamp_q(ii);
            count++;
         end
         shade = tint * COLOR_W'(count);
         r.pixel_index     = INDEX_W'(int'(px.pixel_y) * IMAGE_SIZE + int'(px.pixel_x));
         r.iteration_count = COUNT_W'(count);
         r.pixel_color     = (count == max_iter) ? '0 : shade;
         pending.push_back(r);
      endfunction

      function void check_word(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $error("unexpected result word: pixel_index %0d iteration_count %0d pixel_color %0d",
                   got.pixel_index, got.iteration_count, got.pixel_color);
            faults++;
            return;
         end
         want = pending.pop_front();
         if (got.pixel_index !== want.pixel_index) begin
            $error("pixel_index: expected %0d, actual %0d", want.pixel_index, got.pixel_index);
            faults++;
         end
         if (got.iteration_count !== want.iteration_count) begin
            $error("iteration_count: expected %0d, actual %0d",
                   want.iteration_count, got.iteration_count);
            faults++;
         end
         if (got.pixel_color !== want.pixel_color) begin
            $error("pixel_color: expected %0d, actual %0d", want.pixel_color, got.pixel_color);
            faults++;
         end
      endfunction
   endclass

endpackage

/* dv/mandelbrot_escape_time_pixel_core_tb.sv */
// Self-checking bench for mandelbrot_escape_time_pixel_core: directed corner pixels and
// register extremes, then random views, with random idling on both channels.
// Depends on mbe_pkg, mbe_tb_pkg and the core RTL.
module mandelbrot_escape_time_pixel_core_tb;
   import mbe_pkg::*;
   import mbe_tb_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT  = 600000;
   localparam int unsigned HOLD_OFF_CYCLES = 4000;
   localparam int unsigned DRAIN_CYCLES    = 400;
   localparam int unsigned RANDOM_ITEMS    = 1850;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_word;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_word;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   pixel_scoreboard pixels;
   bit              sender_idles;
   bit              receiver_idles;
   logic            hold_request;
   int unsigned     idle_cycles;

   mandelbrot_escape_time_pixel_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned gap_length();
      int unsigned r;
      r = $urandom_range(99, 0);
      if (r < 70) begin
         return $urandom_range(2, 0);
      end
      if (r < 95) begin
         return $urandom_range(12, 3);
      end
      return $urandom_range(120, 30);
   endfunction

   task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
      req_type     w;
      int unsigned gap;
      w.pixel_x = x;
      w.pixel_y = y;
      gap = sender_idles ? gap_length() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_word  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      pixels.note_pixel(w);
   endtask

   task automatic settle();
      while (pixels.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      pixels.set_register(idx, data);
   endtask

   task automatic load_view(input logic [STEP_W-1:0] step, input logic [VALUE_W-1:0] re,
                            input logic [VALUE_W-1:0] im, input logic [COLOR_W-1:0] tint,
                            input logic [COUNT_W-1:0] lim);
      settle();
      csr_write(CSR_PIXEL_STEP, CSR_DATA_W'(step));
      csr_write(CSR_OFFSET_REAL, re);
      csr_write(CSR_OFFSET_IMAG, im);
      csr_write(CSR_BASE_COLOR, tint);
      csr_write(CSR_ITERATION_LIMIT, CSR_DATA_W'(lim));
      csr_valid <= 1'b0;
   endtask

   // mostly windows around the set, now and then raw register noise
   task automatic random_view();
      int                 center_re;
      int                 center_im;
      logic [STEP_W-1:0]  step;
      logic [COUNT_W-1:0] lim;
      if ($urandom_range(3, 0) != 0) begin
         step = STEP_W'($urandom_range(32'h0010_0000, 32'h0000_1000) >> $urandom_range(6, 0));
         center_re = int'($urandom_range(805306368, 0)) - 603979776;
         center_im = int'($urandom_range(671088640, 0)) - 335544320;
         lim = ($urandom_range(4, 0) == 0) ? COUNT_W'($urandom_range(256, 65))
                                            : COUNT_W'($urandom_range(64, 1));
         load_view(step, center_re - 512 * int'(step), center_im - 512 * int'(step),
                   $urandom(), lim);
      end else begin
         load_view(STEP_W'($urandom()), $urandom(), $urandom(), $urandom(),
                   COUNT_W'($urandom_range(1000, 1)));
      end
   endtask

   task automatic scan_batch(input int unsigned n);
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      bit                 sweep;
      x = COORD_W'($urandom());
      y = COORD_W'($urandom());
      sweep = ($urandom_range(2, 0) == 0);
      repeat (n) begin
         if (sweep) begin
            {y, x} = {y, x} + 1'b1;
         end else begin
            x = COORD_W'($urandom());
            y = COORD_W'($urandom());
         end
         send_pixel(x, y);
      end
      req_valid <= 1'b0;
   endtask

   initial begin : result_sink
      int unsigned run;
      bit          stalled;
      run = 0;
      stalled = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            pixels.check_word(rsp_word);
         end
         if (hold_request) begin
            // hold results back so that the core comes to stall its input
            hold_request <= 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            stalled = 1'b0;
            run = 0;
         end else if (run != 0) begin
            run--;
         end else if (receiver_idles) begin
            stalled = $urandom_range(1, 0);
            run = gap_length();
         end else begin
            stalled = 1'b0;
         end
         rsp_stall <= stalled;
      end
   end

   initial begin : watchdog
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("mandelbrot_escape_time_pixel_core_tb: FAIL");
      $finish;
   end

   initial begin : stimulus
      int unsigned remaining;
      int unsigned n;
      bit          first;
      logic [1:0]  mode;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      hold_request = 1'b0;
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
      pixels = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // corners, alternating bits and points inside the set at reset values
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd0, 10'd1023);
      send_pixel(10'd1023, 10'd0);
      send_pixel(10'h2AA, 10'h155);
      send_pixel(10'h155, 10'h2AA);
      send_pixel(10'd700, 10'd512);
      send_pixel(10'd512, 10'd300);
      req_valid <= 1'b0;

      // zero limit: no iteration, black
      load_view(RESET_PIXEL_STEP, RESET_OFFSET_REAL, RESET_OFFSET_IMAG, RESET_BASE_COLOR, '0);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd700, 10'd512);
      req_valid <= 1'b0;

      load_view(RESET_PIXEL_STEP, RESET_OFFSET_REAL, RESET_OFFSET_IMAG, '1, 16'd1);
      send_pixel(10'd0, 10'd0);
      req_valid <= 1'b0;

      load_view(RESET_PIXEL_STEP, RESET_OFFSET_REAL, RESET_OFFSET_IMAG, '1, 16'd2);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd700, 10'd512);
      req_valid <= 1'b0;

      // zero step maps every pixel to c = 0, which runs to the full limit
      load_view('0, '0, '0, '1, '1);
      send_pixel(10'd1023, 10'd1023);
      req_valid <= 1'b0;

      // largest step from the most negative corner saturates c
      load_view('1, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001, '1);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd2, 10'd1023);
      req_valid <= 1'b0;

      load_view(31'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, 16'd20);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      req_valid <= 1'b0;

      remaining = RANDOM_ITEMS;
      first = 1'b1;
      while (remaining > 0) begin
         random_view();
         mode = 2'($urandom());
         sender_idles = mode[0];
         receiver_idles = mode[1];
         if (first) begin
            sender_idles = 1'b0;
            hold_request <= 1'b1;
            first = 1'b0;
         end
         n = $urandom_range(170, 140);
         if (n > remaining) begin
            n = remaining;
         end
         scan_batch(n);
         remaining -= n;
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pixels.faults == 0) begin
         $display("mandelbrot_escape_time_pixel_core_tb: PASS");
      end else begin
         $display("mandelbrot_escape_time_pixel_core_tb: FAIL");
      end
      $finish;
   end

endmodule
